// ===== rtl/rasd_pkg.sv =====
package rasd_pkg;

  localparam int unsigned IdxW = 10;
  localparam int unsigned LenW = 11;
  localparam int unsigned WordW = 32;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic [IdxW-1:0]         element_index;
    logic signed [WordW-1:0] element_value;
    logic signed [WordW-1:0] search_key;
  } in_beat_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] position;
  } out_beat_t;

  typedef logic [3:0] upc_t;

  localparam upc_t PC_WAIT = 4'd0;
  localparam upc_t PC_LOOP = 4'd1;
  localparam upc_t PC_RD_A = 4'd2;
  localparam upc_t PC_RD_M = 4'd3;
  localparam upc_t PC_DECIDE = 4'd4;
  localparam upc_t PC_SCAN = 4'd5;
  localparam upc_t PC_SCAN_CMP = 4'd6;
  localparam upc_t PC_END = 4'd7;
  localparam upc_t PC_END_LO = 4'd8;
  localparam upc_t PC_END_HI = 4'd9;
  localparam upc_t PC_RESULT = 4'd10;

  typedef enum logic [1:0] {
    ASEL_LO,
    ASEL_MID,
    ASEL_HI,
    ASEL_IDX
  } addr_sel_e;

  typedef enum logic [2:0] {
    UOP_WAIT,
    UOP_TEST,
    UOP_READ,
    UOP_DECIDE,
    UOP_SCAN,
    UOP_END_LO,
    UOP_END_HI,
    UOP_RESULT
  } uop_e;

  typedef struct packed {
    addr_sel_e asel;
    logic      lat_a;
    logic      lat_m;
    uop_e      uop;
    upc_t      jmp;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic zero_len;
    logic loop_done;
    logic hit;
    logic dup;
    logic scan_last;
    logic out_free;
  } seq_flags_t;

  function automatic ctrl_t ucode_rom(input upc_t pc);
    ctrl_t w;
    w = '{asel: ASEL_LO, lat_a: 1'b0, lat_m: 1'b0, uop: UOP_WAIT, jmp: PC_WAIT};
    unique case (pc)
      PC_WAIT: w = '{asel: ASEL_LO, lat_a: 1'b0, lat_m: 1'b0, uop: UOP_WAIT, jmp: PC_WAIT};
      PC_LOOP: w = '{asel: ASEL_LO, lat_a: 1'b0, lat_m: 1'b0, uop: UOP_TEST, jmp: PC_END};
      PC_RD_A: w = '{asel: ASEL_MID, lat_a: 1'b1, lat_m: 1'b0, uop: UOP_READ, jmp: PC_WAIT};
      PC_RD_M: w = '{asel: ASEL_HI, lat_a: 1'b0, lat_m: 1'b1, uop: UOP_READ, jmp: PC_WAIT};
      PC_DECIDE: w = '{asel: ASEL_HI, lat_a: 1'b0, lat_m: 1'b0, uop: UOP_DECIDE, jmp: PC_SCAN};
      PC_SCAN: w = '{asel: ASEL_IDX, lat_a: 1'b0, lat_m: 1'b0, uop: UOP_READ, jmp: PC_WAIT};
      PC_SCAN_CMP: w = '{asel: ASEL_IDX, lat_a: 1'b0, lat_m: 1'b0, uop: UOP_SCAN, jmp: PC_SCAN};
      PC_END: w = '{asel: ASEL_LO, lat_a: 1'b0, lat_m: 1'b0, uop: UOP_READ, jmp: PC_WAIT};
      PC_END_LO: w = '{asel: ASEL_HI, lat_a: 1'b0, lat_m: 1'b0, uop: UOP_END_LO, jmp: PC_WAIT};
      PC_END_HI: w = '{asel: ASEL_HI, lat_a: 1'b0, lat_m: 1'b0, uop: UOP_END_HI, jmp: PC_WAIT};
      PC_RESULT: w = '{asel: ASEL_LO, lat_a: 1'b0, lat_m: 1'b0, uop: UOP_RESULT, jmp: PC_WAIT};
      default: w.uop = UOP_WAIT;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/rasd_seq.sv =====
module rasd_seq
  import rasd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  seq_flags_t flags_i,
  output ctrl_t      ctrl_o
);

  upc_t pc_q, pc_d;
  upc_t pc_inc;

  assign ctrl_o = ucode_rom(pc_q);
  assign pc_inc = pc_q + 4'd1;

  always_comb begin
    pc_d = pc_inc;
    unique case (ctrl_o.uop)
      UOP_WAIT: begin
        if (!flags_i.start) begin
          pc_d = pc_q;
        end else if (flags_i.zero_len) begin
          pc_d = PC_RESULT;
        end
      end
      UOP_TEST: begin
        if (flags_i.loop_done) begin
          pc_d = ctrl_o.jmp;
        end
      end
      UOP_READ: pc_d = pc_inc;
      UOP_DECIDE: begin
        if (flags_i.hit) begin
          pc_d = PC_RESULT;
        end else if (flags_i.dup) begin
          pc_d = ctrl_o.jmp;
        end else begin
          pc_d = PC_LOOP;
        end
      end
      UOP_SCAN: begin
        if (flags_i.hit || flags_i.scan_last) begin
          pc_d = PC_RESULT;
        end else begin
          pc_d = ctrl_o.jmp;
        end
      end
      UOP_END_LO: begin
        if (flags_i.hit) begin
          pc_d = PC_RESULT;
        end
      end
      UOP_END_HI: pc_d = PC_RESULT;
      UOP_RESULT: begin
        pc_d = flags_i.out_free ? ctrl_o.jmp : pc_q;
      end
      default: pc_d = PC_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== rtl/rotated_array_search_with_duplicates_core.sv =====
// Search engine over a rotated ascending array of signed 32-bit words, duplicates allowed.
// Input channel (in_valid_i / in_stall_o / in_data_i): a load beat writes element_value at
// element_index; indexes at or above DEPTH are dropped. A search beat
// runs a binary search for search_key over the first array_length elements and gives one
// result beat (found, position) on the output channel (out_valid_o / out_stall_i).
// Configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes array_length,
// saturated to DEPTH; write it only while the engine is idle.
// Each probe is a loop test, reads of the left, middle and right words and a decision;
// a search takes at most ceil(log2(n-1)) probes, then the final loop test, two end checks
// and the result hand-off; a window with equal ends and middle is scanned in index order.
// The element memory has a single read port that serves one word per cycle.
// A zero length goes straight from the waiting state to the result hand-off as not found.
// in_stall_o is high while a search is in flight. The result sits in an output register,
// so a new beat is accepted while an earlier result is held by out_stall_i; a search that
// finishes while that register is still full waits for it to drain.
// Reset clears array_length, the sequencer and the output valid; memory contents stay
// undefined until loaded.
module rotated_array_search_with_duplicates_core
  import rasd_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_beat_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_beat_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LenW-1:0]  cfg_data_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  logic signed [WordW-1:0] mem [DEPTH];
  logic signed [WordW-1:0] rd_q;
  logic signed [WordW-1:0] a_q, m_q, key_q;
  logic [AW-1:0]           lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, idx_q, idx_d;
  logic [AW-1:0]           rd_addr;
  logic [LenW-1:0]         len_q;
  logic                    res_found_q, res_found_d;
  logic [IdxW-1:0]         res_pos_q, res_pos_d;
  logic                    out_valid_q, out_valid_d;
  out_beat_t               out_data_q, out_data_d;

  ctrl_t                   ctrl;
  seq_flags_t              flags;

  logic                    in_acc, wr_en, load_ok;
  logic [AW+IdxW-1:0]      wr_ext;
  logic [AW-1:0]           wr_addr;
  logic [LenW-1:0]         len_m1;
  logic [AW+LenW-1:0]      len_ext;
  logic [AW-1:0]           init_hi;
  logic [AW:0]             lo_p1, mid_sum;
  logic                    key_eq_rd, key_eq_m;

  function automatic logic [IdxW-1:0] to_pos(input logic [AW-1:0] a);
    logic [AW+IdxW-1:0] e;
    e = {{IdxW{1'b0}}, a};
    return e[IdxW-1:0];
  endfunction

  rasd_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flags_i(flags),
    .ctrl_o (ctrl)
  );

  assign in_stall_o  = ctrl.uop != UOP_WAIT;
  assign cfg_ready_o = ctrl.uop == UOP_WAIT;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign wr_ext  = {{AW{1'b0}}, in_data_i.element_index};
  assign wr_addr = wr_ext[AW-1:0];
  assign load_ok = 32'(in_data_i.element_index) < 32'(DEPTH);
  assign wr_en   = in_acc && (in_data_i.operation == OP_LOAD) && load_ok;

  assign len_m1  = len_q - 11'd1;
  assign len_ext = {{AW{1'b0}}, len_m1};
  assign init_hi = (32'(len_q) >= 32'(DEPTH)) ? LastIdx : len_ext[AW-1:0];

  assign lo_p1     = {1'b0, lo_q} + {{AW{1'b0}}, 1'b1};
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign key_eq_rd = rd_q == key_q;
  assign key_eq_m  = m_q == key_q;

  always_comb begin
    flags.start     = in_acc && (in_data_i.operation == OP_SEARCH);
    flags.zero_len  = len_q == '0;
    flags.loop_done = !(lo_p1 < {1'b0, hi_q});
    flags.hit       = (ctrl.uop == UOP_DECIDE) ? key_eq_m : key_eq_rd;
    flags.dup       = (m_q == a_q) && (m_q == rd_q);
    flags.scan_last = idx_q == hi_q;
    flags.out_free  = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    unique case (ctrl.asel)
      ASEL_LO:  rd_addr = lo_q;
      ASEL_MID: rd_addr = mid_q;
      ASEL_HI:  rd_addr = hi_q;
      ASEL_IDX: rd_addr = idx_q;
      default:  rd_addr = lo_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data_i.element_value;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    idx_d       = idx_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    case (ctrl.uop)
      UOP_WAIT: begin
        if (flags.start) begin
          lo_d        = '0;
          hi_d        = init_hi;
          res_found_d = 1'b0;
          res_pos_d   = '0;
        end
      end
      UOP_TEST: mid_d = mid_sum[AW:1];
      UOP_DECIDE: begin
        if (key_eq_m) begin
          res_found_d = 1'b1;
          res_pos_d   = to_pos(mid_q);
        end else if (flags.dup) begin
          idx_d = lo_q;
        end else if (a_q <= m_q) begin
          if (key_q >= a_q && key_q <= m_q) begin
            hi_d = mid_q;
          end else begin
            lo_d = mid_q;
          end
        end else begin
          if (key_q >= m_q && key_q <= rd_q) begin
            lo_d = mid_q;
          end else begin
            hi_d = mid_q;
          end
        end
      end
      UOP_SCAN: begin
        if (key_eq_rd) begin
          res_found_d = 1'b1;
          res_pos_d   = to_pos(idx_q);
        end else if (!flags.scan_last) begin
          idx_d = idx_q + AW'(1);
        end
      end
      UOP_END_LO: begin
        if (key_eq_rd) begin
          res_found_d = 1'b1;
          res_pos_d   = to_pos(lo_q);
        end
      end
      UOP_END_HI: begin
        if (key_eq_rd) begin
          res_found_d = 1'b1;
          res_pos_d   = to_pos(hi_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    idx_q       <= idx_d;
    res_found_q <= res_found_d;
    res_pos_q   <= res_pos_d;
    out_data_q  <= out_data_d;
    if (flags.start) begin
      key_q <= in_data_i.search_key;
    end
    if (ctrl.lat_a) begin
      a_q <= rd_q;
    end
    if (ctrl.lat_m) begin
      m_q <= rd_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (ctrl.uop == UOP_RESULT && flags.out_free) begin
      out_valid_d         = 1'b1;
      out_data_d.found    = res_found_q;
      out_data_d.position = res_pos_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      len_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        len_q <= cfg_data_i;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.uop == UOP_DECIDE |-> (lo_q < mid_q) && (mid_q < hi_q))
    else $error("probe midpoint outside window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.uop == UOP_SCAN |-> (idx_q >= lo_q) && (idx_q <= hi_q))
    else $error("scan index outside window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.uop == UOP_RESULT && flags.out_free |=> out_valid_o && ctrl.uop == UOP_WAIT)
    else $error("result hand-off did not complete");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.uop == UOP_RESULT && !res_found_q |-> res_pos_q == '0)
    else $error("miss carries nonzero position");

endmodule

// ===== sim/tb_rotated_array_search_with_duplicates_core.sv =====
`timescale 1ns / 1ps

module tb_rotated_array_search_with_duplicates_core;
  import rasd_pkg::*;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned RAND_BEATS = 2000;
  localparam int unsigned SETTLE = 20;
  localparam int unsigned LIMIT = 20000000;
  localparam logic signed [WordW-1:0] WORD_MIN = {1'b1, {(WordW-1){1'b0}}};
  localparam logic signed [WordW-1:0] WORD_MAX = {1'b0, {(WordW-1){1'b1}}};

  class search_ledger;
    logic signed [WordW-1:0] words [DEPTH];
    int unsigned length;
    out_beat_t answers_due [$];
    int unsigned errors;
    int unsigned searches;
    int unsigned hits;
    int unsigned loads;

    function void set_length(logic [LenW-1:0] v);
      length = (v > DEPTH) ? DEPTH : v;
    endfunction

    function out_beat_t locate_key(logic signed [WordW-1:0] key);
      out_beat_t r;
      int unsigned lo, hi, mid, i;
      logic signed [WordW-1:0] a, m, b;
      r = '0;
      if (length == 0) return r;
      lo = 0;
      hi = length - 1;
      while (lo + 1 < hi) begin
        mid = (lo + hi) / 2;
        a = words[lo];
        m = words[mid];
        b = words[hi];
        if (m == key) begin
          r.found = 1'b1;
          r.position = IdxW'(mid);
          return r;
        end
        if (m == a && m == b) begin
          for (i = lo; i <= hi; i++) begin
            if (words[i] == key) begin
              r.found = 1'b1;
              r.position = IdxW'(i);
              return r;
            end
          end
          return r;
        end
        if (a <= m) begin
          if (key >= a && key <= m) hi = mid;
          else lo = mid;
        end else begin
          if (key >= m && key <= b) lo = mid;
          else hi = mid;
        end
      end
      if (words[lo] == key) begin
        r.found = 1'b1;
        r.position = IdxW'(lo);
      end else if (words[hi] == key) begin
        r.found = 1'b1;
        r.position = IdxW'(hi);
      end
      return r;
    endfunction

    function void note_beat(in_beat_t b);
      if (b.operation == OP_LOAD) begin
        words[b.element_index] = b.element_value;
        loads++;
      end else begin
        answers_due.push_back(locate_key(b.search_key));
        searches++;
        if (answers_due[$].found) hits++;
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < 20) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_answer(out_beat_t got);
      out_beat_t want;
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("result beat with none due: found %0b position %0d",
                                  got.found, got.position));
        return;
      end
      want = answers_due.pop_front();
      if (got.found !== want.found)
        report_mismatch($sformatf("found %0b, want %0b", got.found, want.found));
      if (got.position !== want.position)
        report_mismatch($sformatf("position %0d, want %0d", got.position, want.position));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_beat_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_beat_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [LenW-1:0] cfg_data_i;

  search_ledger sb = new;
  bit loaded [DEPTH];
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned beats_sent;
  int unsigned length_writes;
  int unsigned cycles;

  rotated_array_search_with_duplicates_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_answer(out_data_o);
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin
        gap_pct = 0;
        stall_pct = 0;
      end
      1: begin
        gap_pct = 66;
        stall_pct = 0;
      end
      2: begin
        gap_pct = 0;
        stall_pct = 66;
      end
      default: begin
        gap_pct = 25;
        stall_pct = 25;
      end
    endcase
  endtask

  task automatic send_beat(in_beat_t b);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(b);
    beats_sent++;
  endtask

  task automatic load_word(int unsigned idx, logic signed [WordW-1:0] val);
    in_beat_t b;
    b.operation = OP_LOAD;
    b.element_index = IdxW'(idx);
    b.element_value = val;
    b.search_key = $urandom;
    loaded[idx] = 1'b1;
    send_beat(b);
  endtask

  task automatic search_for(logic signed [WordW-1:0] key);
    in_beat_t b;
    b.operation = OP_SEARCH;
    b.element_index = IdxW'($urandom);
    b.element_value = $urandom;
    b.search_key = key;
    send_beat(b);
  endtask

  // hold off input until every result is back and the engine has settled
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.answers_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_length(logic [LenW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_length(v);
    length_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  // sorted values with a chosen spread, rotated, then loaded into 0..n-1
  task automatic build_array(int unsigned n);
    int vals [$];
    int unsigned kind, shift, i;
    int base;
    kind = $urandom_range(3);
    base = $urandom;
    for (i = 0; i < n; i++) begin
      case (kind)
        0: vals.push_back(base);
        1: vals.push_back(base + int'($urandom_range(3)));
        2: vals.push_back(int'($urandom));
        default: vals.push_back(base + int'($urandom_range(n)));
      endcase
    end
    if (kind == 0 && $urandom_range(1) == 1) vals[0] = base + int'($urandom_range(5)) - 2;
    vals.sort();
    shift = $urandom_range(n - 1);
    for (i = 0; i < n; i++) load_word(i, vals[(i + shift) % n]);
  endtask

  task automatic random_search(int unsigned n);
    logic signed [WordW-1:0] key;
    int unsigned r;
    r = $urandom_range(99);
    if (n != 0 && r < 50) key = sb.words[$urandom_range(n - 1)];
    else if (n != 0 && r < 70)
      key = sb.words[$urandom_range(n - 1)] + ($urandom_range(1) ? 1 : -1);
    else if (r < 73) key = WORD_MIN;
    else if (r < 76) key = WORD_MAX;
    else key = $urandom;
    search_for(key);
  endtask

  initial begin
    int unsigned phase, n, ready_words, first_random, i;
    logic [LenW-1:0] len_cfg;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    set_idling(0);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_length(0);
    search_for(0);
    load_word(0, WORD_MIN);
    load_word(1, WORD_MAX);
    drain_results();
    write_length(1);
    search_for(WORD_MIN);
    search_for(WORD_MAX);
    drain_results();
    write_length(2);
    search_for(WORD_MAX);
    search_for(0);
    load_word(0, 3);
    load_word(1, 3);
    load_word(2, 3);
    load_word(3, 3);
    load_word(4, 1);
    load_word(5, 3);
    load_word(6, 3);
    load_word(DEPTH - 1, -1);
    drain_results();
    write_length(7);
    search_for(1);
    search_for(3);
    search_for(2);

    first_random = beats_sent;
    phase = 0;
    while (beats_sent - first_random < RAND_BEATS) begin
      set_idling(phase % 4);
      case (phase)
        3: len_cfg = LenW'(DEPTH);
        6: len_cfg = '1;
        default: begin
          i = $urandom_range(99);
          if (i < 6) len_cfg = 0;
          else if (i < 12) len_cfg = 1;
          else if (i < 18) len_cfg = 2;
          else if (i < 75) len_cfg = LenW'($urandom_range(40, 3));
          else len_cfg = LenW'($urandom_range(200, 41));
        end
      endcase
      n = (len_cfg > DEPTH) ? DEPTH : len_cfg;
      drain_results();
      write_length(len_cfg);
      ready_words = 0;
      while (ready_words < n && loaded[ready_words]) ready_words++;
      if (n != 0 && !(ready_words == n && (phase == 6 || $urandom_range(2) == 0)))
        build_array(n);
      repeat ((n == DEPTH) ? 80 : $urandom_range(40, 10)) begin
        if ($urandom_range(99) < 8) load_word($urandom_range(DEPTH - 1), $urandom);
        if ($urandom_range(99) < 4) drain_results();
        random_search(n);
      end
      phase++;
    end

    drain_results();
    $display("Covered %0d searches (%0d hits) and %0d loads over %0d length settings,",
             sb.searches, sb.hits, sb.loads, length_writes);
    $display("from empty and tiny arrays up to the full depth and a saturated length.");
    if (sb.errors == 0 && sb.answers_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
